// ===== src/swpu_pkg.sv =====
`default_nettype none

package swpu_pkg;

   localparam int SLOTS       = 3;
   localparam int MAT_W       = 8;
   localparam int WT_W        = 16;
   localparam int WONE        = 32768;
   localparam int ENT_N       = SLOTS + 1;
   localparam int CNT_W       = $clog2(SLOTS + 1);
   localparam int RANK_W      = $clog2(ENT_N);
   localparam int PROD_W      = 2 * WT_W;
   localparam int ROUND_SHIFT = WT_W - 1;
   localparam int DELTA_W     = PROD_W - ROUND_SHIFT;
   localparam int RECIP_K     = DELTA_W + 3;
   localparam int RECIP_W     = RECIP_K + 1;
   localparam int RPROD_W     = DELTA_W + RECIP_W;
   localparam int ENT_W       = DELTA_W + 2;
   localparam int SUM_W       = ENT_W + 1;
   localparam longint RECIP_ONE = longint'(1) << RECIP_K;

   typedef struct packed {
      logic [MAT_W-1:0] slot0_material;
      logic [MAT_W-1:0] slot1_material;
      logic [MAT_W-1:0] slot2_material;
      logic [WT_W-1:0]  slot0_weight;
      logic [WT_W-1:0]  slot1_weight;
      logic [WT_W-1:0]  slot2_weight;
      logic [WT_W-1:0]  brush_amount;
      logic [WT_W-1:0]  step_gain;
   } req_type;

   typedef struct packed {
      logic [MAT_W-1:0] new_material0;
      logic [MAT_W-1:0] new_material1;
      logic [MAT_W-1:0] new_material2;
      logic [WT_W-1:0]  new_weight0;
      logic [WT_W-1:0]  new_weight1;
      logic [WT_W-1:0]  new_weight2;
   } rsp_type;

   typedef struct packed {
      logic [SLOTS-1:0][MAT_W-1:0] mat;
      logic [SLOTS-1:0][WT_W-1:0]  wt;
      logic [WT_W-1:0]             amount;
      logic [WT_W-1:0]             gain;
      logic [MAT_W-1:0]            paint;
   } front_in_type;

   typedef struct packed {
      logic             valid;
      logic [MAT_W-1:0] mat;
      logic [ENT_W-1:0] wt;
   } entry_type;

   typedef struct packed {
      logic                       empty;
      entry_type [ENT_N-1:0]      entries;
   } entries_type;

   typedef struct packed {
      logic                       empty;
      entry_type [SLOTS-1:0]      entries;
   } sorted_type;

   typedef struct packed {
      logic [SLOTS-1:0][MAT_W-1:0] mat;
      logic [SLOTS-1:0][WT_W-1:0]  wt;
   } result_type;

   // Reciprocal of the positive-slot count, scaled by 2**RECIP_K and truncated.
   function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] cnt);
      logic [RECIP_W-1:0] r;
      case (int'(cnt))
         1: r = RECIP_W'(RECIP_ONE);
         2: r = RECIP_W'(RECIP_ONE / 2);
         3: r = RECIP_W'(RECIP_ONE / 3);
         4: r = RECIP_W'(RECIP_ONE / 4);
         5: r = RECIP_W'(RECIP_ONE / 5);
         6: r = RECIP_W'(RECIP_ONE / 6);
         7: r = RECIP_W'(RECIP_ONE / 7);
         8: r = RECIP_W'(RECIP_ONE / 8);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== src/swpu_req_if.sv =====
`default_nettype none

interface swpu_req_if
   import swpu_pkg::*;
();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/swpu_rsp_if.sv =====
`default_nettype none

interface swpu_rsp_if
   import swpu_pkg::*;
();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/splat_weight_paint_update_core.sv =====
// Splat weight paint update: rewrites one vertex's three material slots under
// a brush stroke.
// Input channel req_bus carries the slots' material indexes and Q1.15 weights,
// the brush amount and the step gain. Result channel rsp_bus carries the new
// slots, heaviest first, with unused slots zero.
// The painted material is set through csr_write_enable / csr_write_data and
// should only be written while no vertex is in flight.
// The datapath is a seven-register pipeline, and one vertex can be accepted
// every cycle while the receiver keeps up. The stage holding the count
// division by reciprocal multiply and the rank comparison of the four
// candidate entries set the depth.
// When the receiver stalls, each pipeline stage that holds an item keeps it and
// req_bus.ready drops once the pipeline is full; nothing is lost or repeated.
// Synchronous reset empties the pipeline and sets the painted material to 0.
`default_nettype none

module splat_weight_paint_update_core
   import swpu_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   swpu_req_if.sink              req_bus,
   swpu_rsp_if.source            rsp_bus,
   input  wire logic             csr_write_enable,
   input  wire logic [MAT_W-1:0] csr_write_data
);

   logic [MAT_W-1:0] paint_ff, paint_in;

   front_in_type front_in;
   entries_type  front_data;
   sorted_type   sort_data;
   result_type   result;

   logic front_valid, front_ready;
   logic sort_valid, sort_ready;

   assign paint_in = csr_write_enable ? csr_write_data : paint_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         paint_ff <= '0;
      end else begin
         paint_ff <= paint_in;
      end
   end

   always_comb begin
      front_in.mat[0] = req_bus.data.slot0_material;
      front_in.mat[1] = req_bus.data.slot1_material;
      front_in.mat[2] = req_bus.data.slot2_material;
      front_in.wt[0]  = req_bus.data.slot0_weight;
      front_in.wt[1]  = req_bus.data.slot1_weight;
      front_in.wt[2]  = req_bus.data.slot2_weight;
      front_in.amount = req_bus.data.brush_amount;
      front_in.gain   = req_bus.data.step_gain;
      front_in.paint  = paint_ff;
   end

   swpu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_data   (front_in),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_data  (front_data)
   );

   swpu_sort u_sort (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (sort_valid),
      .out_ready (sort_ready),
      .out_data  (sort_data)
   );

   swpu_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sort_valid),
      .in_ready  (sort_ready),
      .in_data   (sort_data),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (result)
   );

   always_comb begin
      rsp_bus.data.new_material0 = result.mat[0];
      rsp_bus.data.new_material1 = result.mat[1];
      rsp_bus.data.new_material2 = result.mat[2];
      rsp_bus.data.new_weight0   = result.wt[0];
      rsp_bus.data.new_weight1   = result.wt[1];
      rsp_bus.data.new_weight2   = result.wt[2];
   end

endmodule

`default_nettype wire

// ===== src/swpu_front.sv =====
`default_nettype none

module swpu_front
   import swpu_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire front_in_type in_data,
   output logic              out_valid,
   input  wire logic         out_ready,
   output entries_type       out_data
);

   typedef struct packed {
      logic [SLOTS-1:0][MAT_W-1:0] mat;
      logic [SLOTS-1:0][WT_W-1:0]  wt;
      logic [SLOTS-1:0]            keep;
      logic [SLOTS-1:0]            is_paint;
      logic                        has_paint;
      logic [CNT_W-1:0]            count;
      logic [MAT_W-1:0]            paint;
      logic [PROD_W-1:0]           prod;
   } s1_type;

   typedef struct packed {
      logic [SLOTS-1:0][MAT_W-1:0] mat;
      logic [SLOTS-1:0][WT_W-1:0]  wt;
      logic [SLOTS-1:0]            keep;
      logic [SLOTS-1:0]            is_paint;
      logic                        has_paint;
      logic [CNT_W-1:0]            count;
      logic [MAT_W-1:0]            paint;
      logic [DELTA_W-1:0]          delta;
      logic [RPROD_W-1:0]          rprod;
   } s2_type;

   typedef struct packed {
      logic [SLOTS-1:0][MAT_W-1:0] mat;
      logic [SLOTS-1:0][WT_W-1:0]  wt;
      logic [SLOTS-1:0]            keep;
      logic [SLOTS-1:0]            is_paint;
      logic                        has_paint;
      logic                        empty;
      logic [MAT_W-1:0]            paint;
      logic [DELTA_W-1:0]          delta;
      logic [DELTA_W-1:0]          share;
   } s3_type;

   localparam int REM_W = DELTA_W + CNT_W;
   localparam logic [PROD_W:0] HALF = (PROD_W + 1)'(1) << (ROUND_SHIFT - 1);

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic en1, en2, en3, en4;

   s1_type      s1_ff, s1_in;
   s2_type      s2_ff, s2_in;
   s3_type      s3_ff, s3_in;
   entries_type s4_ff, s4_in;

   logic [SLOTS-1:0]   pos;
   logic [PROD_W:0]    rounded;
   logic [DELTA_W-1:0] quot;
   logic [REM_W-1:0]   qc;
   logic [REM_W-1:0]   rem;

   // Each stage loads when it is empty or its content moves on in the same cycle.
   assign en4      = !v4_ff || out_ready;
   assign en3      = !v3_ff || en4;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   assign v1_in = en1 ? in_valid : v1_ff;
   assign v2_in = en2 ? v1_ff : v2_ff;
   assign v3_in = en3 ? v2_ff : v3_ff;
   assign v4_in = en4 ? v3_ff : v4_ff;

   // Stage 1: positive slots, first occurrence of each material, brush product.
   always_comb begin
      s1_in       = '0;
      s1_in.mat   = in_data.mat;
      s1_in.wt    = in_data.wt;
      s1_in.paint = in_data.paint;
      s1_in.prod  = PROD_W'(in_data.gain) * PROD_W'(in_data.amount);
      for (int i = 0; i < SLOTS; i++) begin
         pos[i] = in_data.wt[i] != '0;
      end
      for (int i = 0; i < SLOTS; i++) begin
         s1_in.keep[i] = pos[i];
         for (int j = 0; j < i; j++) begin
            if (pos[j] && in_data.mat[j] == in_data.mat[i]) begin
               s1_in.keep[i] = 1'b0;
            end
         end
         s1_in.is_paint[i] = s1_in.keep[i] && in_data.mat[i] == in_data.paint;
         s1_in.count       = s1_in.count + CNT_W'(pos[i]);
      end
      s1_in.has_paint = |s1_in.is_paint;
   end

   // Stage 2: rounded delta, then delta times the reciprocal of the count.
   always_comb begin
      rounded         = {1'b0, s1_ff.prod} + HALF;
      s2_in.mat       = s1_ff.mat;
      s2_in.wt        = s1_ff.wt;
      s2_in.keep      = s1_ff.keep;
      s2_in.is_paint  = s1_ff.is_paint;
      s2_in.has_paint = s1_ff.has_paint;
      s2_in.count     = s1_ff.count;
      s2_in.paint     = s1_ff.paint;
      s2_in.delta     = rounded[ROUND_SHIFT +: DELTA_W];
      s2_in.rprod     = RPROD_W'(s2_in.delta) * RPROD_W'(recip_of(s1_ff.count));
   end

   // Stage 3: the quotient from the truncated reciprocal is at most one low; fix it with the remainder.
   always_comb begin
      quot            = s2_ff.rprod[RECIP_K +: DELTA_W];
      qc              = REM_W'(quot) * REM_W'(s2_ff.count);
      rem             = REM_W'(s2_ff.delta) - qc;
      s3_in.mat       = s2_ff.mat;
      s3_in.wt        = s2_ff.wt;
      s3_in.keep      = s2_ff.keep;
      s3_in.is_paint  = s2_ff.is_paint;
      s3_in.has_paint = s2_ff.has_paint;
      s3_in.empty     = s2_ff.count == '0;
      s3_in.paint     = s2_ff.paint;
      s3_in.delta     = s2_ff.delta;
      s3_in.share     = quot + DELTA_W'(rem >= REM_W'(s2_ff.count));
   end

   // Stage 4: build the entry list, with the painted material appended if absent.
   always_comb begin
      s4_in.empty = s3_ff.empty;
      for (int i = 0; i < SLOTS; i++) begin
         s4_in.entries[i].valid = s3_ff.keep[i];
         s4_in.entries[i].mat   = s3_ff.mat[i];
         if (s3_ff.is_paint[i]) begin
            s4_in.entries[i].wt = ENT_W'(s3_ff.wt[i]) + ENT_W'(s3_ff.delta);
         end else begin
            s4_in.entries[i].wt = ENT_W'(s3_ff.wt[i]) - ENT_W'(s3_ff.share);
         end
      end
      s4_in.entries[SLOTS].valid = !s3_ff.has_paint;
      s4_in.entries[SLOTS].mat   = s3_ff.paint;
      s4_in.entries[SLOTS].wt    = ENT_W'(s3_ff.delta);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_ff <= s1_in;
      end
      if (en2) begin
         s2_ff <= s2_in;
      end
      if (en3) begin
         s3_ff <= s3_in;
      end
      if (en4) begin
         s4_ff <= s4_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_data  = s4_ff;

endmodule

`default_nettype wire

// ===== src/swpu_sort.sv =====
`default_nettype none

module swpu_sort
   import swpu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire entries_type in_data,
   output logic             out_valid,
   input  wire logic        out_ready,
   output sorted_type       out_data
);

   typedef struct packed {
      entries_type                 ent;
      logic [ENT_N-1:0][RANK_W-1:0] rank;
   } ranked_type;

   logic v1_ff, v2_ff;
   logic v1_in, v2_in;
   logic en1, en2;

   ranked_type r_ff, r_in;
   sorted_type o_ff, o_in;

   logic beats;

   assign en2      = !v2_ff || out_ready;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;
   assign v1_in    = en1 ? in_valid : v1_ff;
   assign v2_in    = en2 ? v1_ff : v2_ff;

   // Rank of an entry: how many valid entries come before it. Material indexes
   // of valid entries are distinct, so the ranks of valid entries are distinct.
   always_comb begin
      beats = 1'b0;
      r_in.ent  = in_data;
      r_in.rank = '0;
      for (int i = 0; i < ENT_N; i++) begin
         for (int j = 0; j < ENT_N; j++) begin
            beats = $signed(in_data.entries[j].wt) > $signed(in_data.entries[i].wt)
               || (in_data.entries[j].wt == in_data.entries[i].wt
               && in_data.entries[j].mat > in_data.entries[i].mat);
            if (j != i && in_data.entries[j].valid && beats) begin
               r_in.rank[i] = r_in.rank[i] + RANK_W'(1);
            end
         end
      end
   end

   always_comb begin
      o_in       = '0;
      o_in.empty = r_ff.ent.empty;
      for (int p = 0; p < SLOTS; p++) begin
         for (int i = 0; i < ENT_N; i++) begin
            if (r_ff.ent.entries[i].valid && r_ff.rank[i] == RANK_W'(p)) begin
               o_in.entries[p] = r_ff.ent.entries[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         r_ff <= r_in;
      end
      if (en2) begin
         o_ff <= o_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = o_ff;

endmodule

`default_nettype wire

// ===== src/swpu_pack.sv =====
`default_nettype none

module swpu_pack
   import swpu_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire sorted_type in_data,
   output logic            out_valid,
   input  wire logic       out_ready,
   output result_type      out_data
);

   localparam logic signed [SUM_W-1:0] WONE_S = SUM_W'(WONE);

   logic       valid_ff, valid_in;
   result_type res_ff, res_in;

   logic signed [SUM_W-1:0] sum;
   logic signed [SUM_W-1:0] w;
   logic                    stop;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Walk the sorted entries, stopping at the first non-positive weight or once
   // the running total reaches one; the entry that reaches one is cut to fit.
   always_comb begin
      res_in = '0;
      sum    = '0;
      w      = '0;
      stop   = 1'b0;
      for (int p = 0; p < SLOTS; p++) begin
         w = SUM_W'($signed(in_data.entries[p].wt));
         if (!stop) begin
            if (!in_data.entries[p].valid || w <= 0 || sum >= WONE_S) begin
               stop = 1'b1;
            end else begin
               res_in.mat[p] = in_data.entries[p].mat;
               if (sum + w >= WONE_S) begin
                  res_in.wt[p] = WT_W'(WONE_S - sum);
               end else begin
                  res_in.wt[p] = WT_W'(w);
               end
               sum = sum + w;
            end
         end
      end
      if (in_data.empty) begin
         res_in       = '0;
         res_in.wt[0] = WT_W'(WONE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         res_ff <= res_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = res_ff;

endmodule

`default_nettype wire

// ===== verif/swpu_paint_checker.sv =====
`timescale 1ns / 100ps

module swpu_paint_checker
   import swpu_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   swpu_req_if                   req_bus,
   swpu_rsp_if                   rsp_bus,
   input  wire logic             csr_write_enable,
   input  wire logic [MAT_W-1:0] csr_write_data,
   output int                    mismatches,
   output int                    outstanding
);

   logic [MAT_W-1:0] paint_reg;
   rsp_type          painted_q[$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
      paint_reg   = '0;
   end

   // Blends one vertex the way the block should: painted material gains the
   // rounded product, others lose an even share, then sort and cap at one.
   function automatic rsp_type paint_vertex(input req_type v, input logic [MAT_W-1:0] paint);
      logic [MAT_W-1:0] in_mat [SLOTS];
      logic [WT_W-1:0]  in_wt [SLOTS];
      logic [MAT_W-1:0] cand_mat [ENT_N];
      longint           cand_wt [ENT_N];
      logic [MAT_W-1:0] out_mat [SLOTS];
      logic [WT_W-1:0]  out_wt [SLOTS];
      longint           delta;
      longint           share;
      longint           total;
      longint           tw;
      logic [MAT_W-1:0] tm;
      int               n;
      int               live;
      int               best;
      bit               dup;
      bit               paint_seen;
      rsp_type          r;

      in_mat = '{v.slot0_material, v.slot1_material, v.slot2_material};
      in_wt  = '{v.slot0_weight, v.slot1_weight, v.slot2_weight};
      n = 0;
      live = 0;
      total = 0;
      paint_seen = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         out_mat[i] = '0;
         out_wt[i]  = '0;
         if (in_wt[i] != 0) live++;
      end
      delta = (longint'(v.step_gain) * longint'(v.brush_amount) + 16384) >> 15;

      if (live == 0) begin
         out_wt[0] = WT_W'(WONE);
      end else begin
         share = delta / live;
         for (int i = 0; i < SLOTS; i++) begin
            dup = 1'b0;
            for (int j = 0; j < n; j++)
               if (cand_mat[j] == in_mat[i]) dup = 1'b1;
            if (in_wt[i] != 0 && !dup) begin
               cand_mat[n] = in_mat[i];
               if (in_mat[i] == paint) begin
                  paint_seen = 1'b1;
                  cand_wt[n] = longint'(in_wt[i]) + delta;
               end else begin
                  cand_wt[n] = longint'(in_wt[i]) - share;
               end
               n++;
            end
         end
         if (!paint_seen) begin
            cand_mat[n] = paint;
            cand_wt[n]  = delta;
            n++;
         end
         for (int i = 0; i < n; i++) begin
            best = i;
            for (int j = i + 1; j < n; j++)
               if (cand_wt[j] > cand_wt[best] ||
                   (cand_wt[j] == cand_wt[best] && cand_mat[j] > cand_mat[best]))
                  best = j;
            tw = cand_wt[i];
            tm = cand_mat[i];
            cand_wt[i]     = cand_wt[best];
            cand_mat[i]    = cand_mat[best];
            cand_wt[best]  = tw;
            cand_mat[best] = tm;
         end
         for (int i = 0; i < n && i < SLOTS; i++) begin
            if (cand_wt[i] <= 0 || total >= WONE) break;
            out_mat[i] = cand_mat[i];
            if (total + cand_wt[i] >= WONE)
               out_wt[i] = WT_W'(WONE - total);
            else
               out_wt[i] = WT_W'(cand_wt[i]);
            total += cand_wt[i];
         end
      end

      r.new_material0 = out_mat[0];
      r.new_material1 = out_mat[1];
      r.new_material2 = out_mat[2];
      r.new_weight0   = out_wt[0];
      r.new_weight1   = out_wt[1];
      r.new_weight2   = out_wt[2];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic check_field(input string what, input longint got, input longint want);
      if (got != want) report_mismatch(what, got, want);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         paint_reg = '0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            painted_q = {painted_q, paint_vertex(req_bus.data, paint_reg)};
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = rsp_bus.data;
            if (painted_q.size() == 0) begin
               report_mismatch("unexpected result transfer", 1, 0);
            end else begin
               want = painted_q.pop_front();
               check_field("new_material0", got.new_material0, want.new_material0);
               check_field("new_material1", got.new_material1, want.new_material1);
               check_field("new_material2", got.new_material2, want.new_material2);
               check_field("new_weight0", got.new_weight0, want.new_weight0);
               check_field("new_weight1", got.new_weight1, want.new_weight1);
               check_field("new_weight2", got.new_weight2, want.new_weight2);
            end
         end
         if (csr_write_enable) paint_reg = csr_write_data;
      end
      outstanding = painted_q.size();
   end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import swpu_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int SEGMENTS     = 6;
   localparam int SEGMENT_SIZE = 240;

   logic             clock;
   logic             reset;
   logic             csr_write_enable;
   logic [MAT_W-1:0] csr_write_data;
   logic [MAT_W-1:0] paint_now;
   int               mismatches;
   int               outstanding;
   int               send_idle_pct;
   int               recv_idle_pct;
   int               cycle_count;

   swpu_req_if req_bus ();
   swpu_rsp_if rsp_bus ();

   splat_weight_paint_update_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   swpu_paint_checker paint_checker (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatches       (mismatches),
      .outstanding      (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_bus.valid = 1'b0;
      req_bus.data = '0;
      rsp_bus.ready = 1'b0;
      send_idle_pct = 25;
      recv_idle_pct = 65;
   end

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL splat_weight_paint_update_core");
         $finish;
      end
   end

   // Mostly in range, with some zeros, full weights, tiny weights and raw
   // 16-bit values that may lie beyond one.
   function automatic logic [WT_W-1:0] rand_weight();
      int pick;
      pick = $urandom_range(99);
      if (pick < 15) return '0;
      else if (pick < 25) return WT_W'(WONE);
      else if (pick < 35) return WT_W'($urandom_range(64, 1));
      else if (pick < 40) return WT_W'($urandom_range(65535));
      else return WT_W'($urandom_range(WONE));
   endfunction

   // Draws slot materials from a small pool so that the painted material and
   // repeated indexes show up often.
   function automatic logic [MAT_W-1:0] rand_material(input logic [MAT_W-1:0] paint,
                                                      input logic [MAT_W-1:0] alt_a,
                                                      input logic [MAT_W-1:0] alt_b);
      int pick;
      pick = $urandom_range(9);
      if (pick < 4) return paint;
      else if (pick < 6) return alt_a;
      else if (pick < 8) return alt_b;
      else return MAT_W'($urandom_range(255));
   endfunction

   // Holds valid across back-to-back transfers and only drops it for a gap.
   task automatic send_vertex(input req_type v);
      if ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_bus.valid <= 1'b1;
      req_bus.data  <= v;
      do @(negedge clock); while (!req_bus.ready);
      @(posedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   task automatic write_paint(input logic [MAT_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      paint_now = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_fields(input logic [MAT_W-1:0] m0, input logic [MAT_W-1:0] m1,
                              input logic [MAT_W-1:0] m2, input logic [WT_W-1:0] w0,
                              input logic [WT_W-1:0] w1, input logic [WT_W-1:0] w2,
                              input logic [WT_W-1:0] amount, input logic [WT_W-1:0] gain);
      req_type v;
      v.slot0_material = m0;
      v.slot1_material = m1;
      v.slot2_material = m2;
      v.slot0_weight   = w0;
      v.slot1_weight   = w1;
      v.slot2_weight   = w2;
      v.brush_amount   = amount;
      v.step_gain      = gain;
      send_vertex(v);
   endtask

   initial begin
      logic [MAT_W-1:0] paint_plan [SEGMENTS];
      logic [MAT_W-1:0] alt_a;
      logic [MAT_W-1:0] alt_b;
      req_type          v;

      paint_now = '0;
      paint_plan = '{8'd255, 8'd0, 8'd37, MAT_W'($urandom_range(255)), 8'd1, 8'd128};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed vertices with the painted material still at its reset value.
      send_fields(9, 8, 7, 0, 0, 0, WONE, WONE);
      send_fields(0, 0, 0, 0, 0, 0, 0, 0);
      send_fields(0, 0, 0, WONE, WONE, WONE, WONE, WONE);
      send_fields(1, 2, 3, 10000, 10000, 10000, 0, 0);
      send_fields(1, 2, 3, 10000, 10000, 10000, WONE, 16384);
      send_fields(0, 1, 2, 100, 200, 300, WONE, WONE);
      send_fields(5, 5, 6, 1000, 2000, 3000, 16384, 16384);
      send_fields(255, 255, 255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_fields(0, 4, 4, 0, 5000, 6000, 100, 200);
      send_fields(3, 0, 3, 20000, 1, 30000, 1, 1);
      send_fields(8, 9, 0, 16384, 16384, 0, WONE, 1);
      send_fields(200, 100, 50, 32767, 1, 1, 16'hFFFF, 1);
      send_fields(8'hAA, 8'h55, 8'hFF, 16'h5555, 16'hAAAA, 16'h8000, 16'h7FFF, 16'hFFFF);
      send_fields(8'h55, 8'hAA, 8'h00, 16'hAAAA, 16'h5555, 16'h0001, 16'h8000, 16'h7FFF);
      send_fields(0, 7, 9, WONE, 0, 0, WONE, WONE);
      send_fields(7, 0, 9, 1, 1, 1, WONE, WONE);
      send_fields(1, 2, 3, 1, 2, 3, 16384, 16384);

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         drain();
         if (seg < 2) begin
            send_idle_pct = 25;
            recv_idle_pct = 65;
         end else if (seg < 4) begin
            send_idle_pct = 65;
            recv_idle_pct = 25;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_paint(paint_plan[seg]);
         for (int k = 0; k < SEGMENT_SIZE; k++) begin
            alt_a = MAT_W'($urandom_range(255));
            alt_b = MAT_W'($urandom_range(255));
            v.slot0_material = rand_material(paint_now, alt_a, alt_b);
            v.slot1_material = rand_material(paint_now, alt_a, alt_b);
            v.slot2_material = rand_material(paint_now, alt_a, alt_b);
            v.slot0_weight   = rand_weight();
            v.slot1_weight   = rand_weight();
            v.slot2_weight   = rand_weight();
            v.brush_amount   = rand_weight();
            v.step_gain      = rand_weight();
            send_vertex(v);
         end
      end

      drain();
      repeat (16) @(posedge clock);
      if (mismatches == 0)
         $display("PASS splat_weight_paint_update_core");
      else
         $display("FAIL splat_weight_paint_update_core");
      $finish;
   end

endmodule
